### hw/rtl/pfde_pkg.sv
// Shared constants, types and helper functions for the page frame store draw engine.
`timescale 1ns / 1ps
package pfde_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int SCREEN_ROWS  = 64;
  localparam int PAGE_COUNT   = (SCREEN_ROWS + 7) / 8;
  localparam int STORE_BYTES  = SCREEN_WIDTH * PAGE_COUNT;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int COL_W   = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LIM_MAX = (SCREEN_WIDTH > SCREEN_ROWS) ? SCREEN_WIDTH : SCREEN_ROWS;
  localparam int POS_W   = $clog2(LIM_MAX);
  localparam int CNT_W   = $clog2(LIM_MAX + 1);
  localparam int CLIP_W  = 20;

  typedef logic signed [CLIP_W-1:0] clip_t;

  localparam clip_t WIDTH_LIM = clip_t'(SCREEN_WIDTH);
  localparam clip_t ROWS_LIM  = clip_t'(SCREEN_ROWS);

  localparam logic [2:0] CMD_PIXEL = 3'd0;
  localparam logic [2:0] CMD_HSPAN = 3'd1;
  localparam logic [2:0] CMD_VSPAN = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] COLOUR_CLEAR  = 2'd0;
  localparam logic [1:0] COLOUR_SET    = 2'd1;
  localparam logic [1:0] COLOUR_TOGGLE = 2'd2;
  localparam logic [1:0] COLOUR_NONE   = 2'd3;

  typedef struct packed {
    logic             none;
    logic [POS_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] ortho;
  } clip_res_t;

  typedef struct packed {
    logic              rd;
    logic              rmw;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } store_req_t;

  function automatic logic [ADDR_W-1:0] page_base(input logic [PAGE_W-1:0] page);
    page_base = ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH));
  endfunction

  function automatic logic [7:0] head_mask(input logic [2:0] lo);
    head_mask = 8'hFF << lo;
  endfunction

  function automatic logic [7:0] tail_mask(input logic [2:0] hi);
    tail_mask = 8'hFF >> (3'd7 - hi);
  endfunction

  function automatic logic [7:0] paint_byte(input logic [1:0] mode, input logic [7:0] d,
                                            input logic [7:0] m);
    case (mode)
      COLOUR_CLEAR:  paint_byte = d & ~m;
      COLOUR_SET:    paint_byte = d | m;
      COLOUR_TOGGLE: paint_byte = d ^ m;
      default:       paint_byte = d;
    endcase
  endfunction

endpackage

### hw/rtl/page_framebuffer_draw_engine_top.sv
// Top level of the page frame store draw engine: command sequencer and result register.
//
// Usage: commands enter on in_valid / in_stall (cmd, x_pos, y_pos, span_len, colour_mode);
// one result beat per command leaves on out_valid / out_stall (read_data, no_effect).
// row_doubling is written on cfg_valid / cfg_ready; cfg_ready is always high.
// One command is worked at a time; in_stall is high until its result is queued.
// A draw walks the store one byte per cycle through a shared read-modify-write unit,
// after the clip and setup states and before a drain state; it touches one byte per
// column for a horizontal span, per page for a vertical span, and one for a pixel.
// Clipped-away draws skip the walk.
// Clear store zeroes all STORE_BYTES bytes, one byte written per cycle.
// Read byte fetches the addressed byte; unknown commands go straight to the result.
// Reset: synchronous rst sets row_doubling to 1 and starts a clearing pass over
// all STORE_BYTES bytes during which in_stall stays high.
// The result sits in an output register; while out_stall holds it, the next
// command is still accepted and worked, and only its result waits for the slot.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] span_len,
  input  logic [1:0]         colour_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic               no_effect
);
  import pfde_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLIP  = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_SPAN  = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_CLEAR = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state;
  logic              row_doubling;
  logic              vert;
  logic [1:0]        mode;
  logic [7:0]        res_data;
  logic              res_none;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  nbytes;
  logic [PAGE_W-1:0] pg;
  logic [PAGE_W-1:0] first_pg;
  logic [PAGE_W-1:0] last_pg;
  logic [7:0]        first_mask;
  logic [7:0]        last_mask;
  logic [7:0]        bit_mask;

  logic              accept;
  logic              out_free;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  clip_res_t         clip_res;
  store_req_t        req;
  logic [7:0]        rd_byte;
  logic [7:0]        cur_mask;

  logic [ADDR_W-1:0] set_addr;
  logic [CNT_W-1:0]  set_nbytes;
  logic [PAGE_W-1:0] set_first_pg;
  logic [PAGE_W-1:0] set_last_pg;
  logic [CNT_W-1:0]  end_sum;
  logic [POS_W-1:0]  end_row;
  logic [ADDR_W-1:0] stride;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign stride    = vert ? ADDR_W'(SCREEN_WIDTH) : ADDR_W'(1);

  assign rd_ok   = !x_pos[15] && (x_pos < 16'(SCREEN_WIDTH)) &&
                   !y_pos[15] && (y_pos < 16'(PAGE_COUNT));
  assign rd_addr = ADDR_W'(x_pos[COL_W-1:0]) + page_base(y_pos[PAGE_W-1:0]);

  pfde_clip u_clip (
    .clk          (clk),
    .load         (accept),
    .step         (state == S_CLIP),
    .cmd          (cmd),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .span_len     (span_len),
    .row_doubling (row_doubling),
    .res          (clip_res)
  );

  pfde_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .mode    (mode),
    .rd_data (rd_byte)
  );

  always_comb begin
    end_sum = CNT_W'(clip_res.start) + clip_res.count - CNT_W'(1);
    end_row = POS_W'(end_sum);
    if (vert) begin
      set_first_pg = PAGE_W'(clip_res.start >> 3);
      set_last_pg  = PAGE_W'(end_row >> 3);
      set_addr     = ADDR_W'(clip_res.ortho) + page_base(set_first_pg);
      set_nbytes   = CNT_W'(set_last_pg - set_first_pg) + CNT_W'(1);
    end else begin
      set_first_pg = PAGE_W'(clip_res.ortho >> 3);
      set_last_pg  = set_first_pg;
      set_addr     = ADDR_W'(clip_res.start) + page_base(set_first_pg);
      set_nbytes   = clip_res.count;
    end
  end

  always_comb begin
    if (vert) begin
      cur_mask = ((pg == first_pg) ? first_mask : 8'hFF) &
                 ((pg == last_pg) ? last_mask : 8'hFF);
    end else begin
      cur_mask = bit_mask;
    end
  end

  always_comb begin
    req      = '0;
    req.addr = addr;
    req.mask = cur_mask;
    case (state)
      S_INIT, S_CLEAR: req.clr = 1'b1;
      S_SPAN:          req.rmw = 1'b1;
      S_IDLE: begin
        req.rd   = accept && (cmd == CMD_READ) && rd_ok;
        req.addr = rd_addr;
      end
      default: req = req;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_doubling <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      row_doubling <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      addr  <= '0;
    end else begin
      case (state)
        S_INIT: begin
          addr <= addr + ADDR_W'(1);
          if (addr == ADDR_W'(STORE_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_PIXEL, CMD_HSPAN, CMD_VSPAN: state <= S_CLIP;
              CMD_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              CMD_READ: state <= rd_ok ? S_READ : S_DONE;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_CLIP: state <= S_SETUP;
        S_SETUP: begin
          if (clip_res.none) begin
            state <= S_DONE;
          end else begin
            addr  <= set_addr;
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          addr <= addr + stride;
          if (nbytes == CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DONE;
        S_CLEAR: begin
          addr <= addr + ADDR_W'(1);
          if (addr == ADDR_W'(STORE_BYTES - 1)) begin
            state <= S_DONE;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode     <= colour_mode;
          vert     <= (cmd == CMD_VSPAN);
          res_data <= 8'h00;
          res_none <= (cmd > CMD_READ) || ((cmd == CMD_READ) && !rd_ok);
        end
      end
      S_SETUP: begin
        res_none   <= clip_res.none;
        nbytes     <= set_nbytes;
        pg         <= set_first_pg;
        first_pg   <= set_first_pg;
        last_pg    <= set_last_pg;
        first_mask <= head_mask(clip_res.start[2:0]);
        last_mask  <= tail_mask(end_row[2:0]);
        bit_mask   <= 8'h01 << clip_res.ortho[2:0];
      end
      S_SPAN: begin
        nbytes <= nbytes - CNT_W'(1);
        pg     <= pg + PAGE_W'(1);
      end
      S_READ: res_data <= rd_byte;
      default: res_data <= res_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      read_data <= res_data;
      no_effect <= res_none;
    end
  end

endmodule

### hw/rtl/pfde_clip.sv
// Two-step span clipper: trims start and length against the screen edges.
`timescale 1ns / 1ps
module pfde_clip (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [2:0]            cmd,
  input  logic signed [15:0]    x_pos,
  input  logic signed [15:0]    y_pos,
  input  logic signed [15:0]    span_len,
  input  logic                  row_doubling,
  output pfde_pkg::clip_res_t   res
);
  import pfde_pkg::*;

  clip_t y_ext;
  clip_t y_use;
  clip_t x_ext;
  clip_t a;
  clip_t c;
  clip_t l;
  clip_t lim_a;
  clip_t lim_c;
  clip_t l1;
  clip_t a1;
  logic  c_ok;

  clip_t a1_q;
  clip_t l1_q;
  clip_t lim_q;
  clip_t c_q;
  logic  c_ok_q;

  clip_t sum;
  clip_t l2;

  always_comb begin
    x_ext = clip_t'(x_pos);
    y_ext = clip_t'(y_pos);
    y_use = row_doubling ? (y_ext <<< 1) : y_ext;
    if (cmd == CMD_VSPAN) begin
      a     = y_use;
      c     = x_ext;
      lim_a = ROWS_LIM;
      lim_c = WIDTH_LIM;
    end else begin
      a     = x_ext;
      c     = y_use;
      lim_a = WIDTH_LIM;
      lim_c = ROWS_LIM;
    end
    l    = (cmd == CMD_PIXEL) ? clip_t'(1) : clip_t'(span_len);
    c_ok = (c >= 0) && (c < lim_c);
    if (a < 0) begin
      l1 = l + a;
      a1 = '0;
    end else begin
      l1 = l;
      a1 = a;
    end
  end

  always_comb begin
    sum = a1_q + l1_q;
    l2  = (sum > lim_q) ? (lim_q - a1_q) : l1_q;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a1_q   <= a1;
      l1_q   <= l1;
      lim_q  <= lim_a;
      c_q    <= c;
      c_ok_q <= c_ok;
    end
    if (step) begin
      res.none  <= !c_ok_q || (l2 <= 0);
      res.start <= POS_W'(a1_q);
      res.count <= CNT_W'(l2);
      res.ortho <= POS_W'(c_q);
    end
  end

endmodule

### hw/rtl/pfde_store.sv
// Frame store memory with a pipelined read-modify-write path and a clear write.
`timescale 1ns / 1ps
module pfde_store (
  input  logic                  clk,
  input  logic                  rst,
  input  pfde_pkg::store_req_t  req,
  input  logic [1:0]            mode,
  output logic [7:0]            rd_data
);
  import pfde_pkg::*;

  logic [7:0]        mem [STORE_BYTES];
  logic              wb_valid;
  logic [ADDR_W-1:0] wb_addr;
  logic [7:0]        wb_mask;

  always_ff @(posedge clk) begin
    if (req.rd || req.rmw) begin
      rd_data <= mem[req.addr];
    end
    if (req.clr) begin
      mem[req.addr] <= 8'h00;
    end else if (wb_valid) begin
      mem[wb_addr] <= paint_byte(mode, rd_data, wb_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= req.rmw;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rmw) begin
      wb_addr <= req.addr;
      wb_mask <= req.mask;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the page frame store draw engine.
`timescale 1ns / 1ps
module tb;
  import pfde_pkg::*;

  localparam int CMD_CODE_MAX    = 7;
  localparam int PHASE_ITEMS     = 280;
  localparam int PRESSURE_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       none;
  } reply_t;

  class draw_scoreboard;
    logic [7:0] frame [STORE_BYTES];
    bit         doubling;
    reply_t     replies_due[$];
    int         errors;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      doubling = 1'b1;
      errors   = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void plot(int col, int row, logic [1:0] colour);
      int         idx;
      logic [7:0] bitmask;
      idx     = col + (row / 8) * SCREEN_WIDTH;
      bitmask = 8'h01 << (row % 8);
      case (colour)
        COLOUR_CLEAR:  frame[idx] = frame[idx] & ~bitmask;
        COLOUR_SET:    frame[idx] = frame[idx] | bitmask;
        COLOUR_TOGGLE: frame[idx] = frame[idx] ^ bitmask;
        default: ;
      endcase
    endfunction

    function void take_command(logic [2:0] op, logic signed [15:0] xs,
                               logic signed [15:0] ys, logic signed [15:0] ls,
                               logic [1:0] colour);
      int     x;
      int     y;
      int     len;
      reply_t r;
      x   = xs;
      y   = ys;
      len = ls;
      r   = '0;
      if (doubling && op <= CMD_VSPAN) y = y * 2;
      case (op)
        CMD_PIXEL: begin
          if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_ROWS) plot(x, y, colour);
          else r.none = 1'b1;
        end
        CMD_HSPAN: begin
          if (y >= 0 && y < SCREEN_ROWS) begin
            if (x < 0) begin
              len = len + x;
              x   = 0;
            end
            if (x + len > SCREEN_WIDTH) len = SCREEN_WIDTH - x;
            if (len > 0) begin
              for (int i = 0; i < len; i++) plot(x + i, y, colour);
            end else begin
              r.none = 1'b1;
            end
          end else begin
            r.none = 1'b1;
          end
        end
        CMD_VSPAN: begin
          if (x >= 0 && x < SCREEN_WIDTH) begin
            if (y < 0) begin
              len = len + y;
              y   = 0;
            end
            if (y + len > SCREEN_ROWS) len = SCREEN_ROWS - y;
            if (len > 0) begin
              for (int i = 0; i < len; i++) plot(x, y + i, colour);
            end else begin
              r.none = 1'b1;
            end
          end else begin
            r.none = 1'b1;
          end
        end
        CMD_CLEAR: begin
          foreach (frame[i]) frame[i] = 8'h00;
        end
        CMD_READ: begin
          if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < PAGE_COUNT)
            r.data = frame[x + y * SCREEN_WIDTH];
          else
            r.none = 1'b1;
        end
        default: r.none = 1'b1;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [7:0] data, logic none);
      reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $error("unexpected result beat: read_data %0h no_effect %0b", data, none);
        return;
      end
      want = replies_due.pop_front();
      if (data !== want.data) begin
        errors++;
        $error("read_data: expected %0h, actual %0h", want.data, data);
      end
      if (none !== want.none) begin
        errors++;
        $error("no_effect: expected %0b, actual %0b", want.none, none);
      end
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_valid   = 1'b0;
  logic               cfg_data    = 1'b0;
  logic               in_valid    = 1'b0;
  logic [2:0]         cmd         = CMD_PIXEL;
  logic signed [15:0] x_pos       = '0;
  logic signed [15:0] y_pos       = '0;
  logic signed [15:0] span_len    = '0;
  logic [1:0]         colour_mode = COLOUR_CLEAR;
  logic               out_stall   = 1'b0;
  logic               cfg_ready;
  logic               in_stall;
  logic               out_valid;
  logic [7:0]         read_data;
  logic               no_effect;

  draw_scoreboard board = new();
  int             send_quiet = 0;

  page_framebuffer_draw_engine_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .span_len    (span_len),
    .colour_mode (colour_mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .no_effect   (no_effect)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.take_command(cmd, x_pos, y_pos, span_len, colour_mode);
      if (out_valid && !out_stall) board.check_reply(read_data, no_effect);
    end
  end

  // receiver: random stalls, quiet stretches, and two long hold-offs
  initial begin
    int hold;
    int beats;
    int quiet;
    beats = 0;
    quiet = 0;
    forever begin
      if (beats == 150 || beats == 700) begin
        hold = PRESSURE_CYCLES;
      end else if (quiet > 0) begin
        quiet--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0) quiet = 40;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  task automatic send_command(logic [2:0] op, logic signed [15:0] xs, logic signed [15:0] ys,
                              logic signed [15:0] ls, logic [1:0] colour);
    int gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) send_quiet = 40;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    x_pos       <= xs;
    y_pos       <= ys;
    span_len    <= ls;
    colour_mode <= colour;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_setting(logic doubling);
    cfg_valid <= 1'b1;
    cfg_data  <= doubling;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    board.doubling = doubling;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick(int lo, int hi);
    if ($urandom_range(0, 11) == 0) return 16'($urandom);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic random_command();
    int                 r;
    int                 rows;
    logic [2:0]         op;
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] ls;
    logic [1:0]         colour;
    rows   = board.doubling ? SCREEN_ROWS / 2 : SCREEN_ROWS;
    r      = $urandom_range(0, 99);
    xs     = 16'($urandom);
    ys     = 16'($urandom);
    ls     = 16'($urandom);
    colour = ($urandom_range(0, 9) == 0) ? COLOUR_NONE : 2'($urandom_range(0, 2));
    if (r < 25) begin
      op = CMD_PIXEL;
      xs = pick(-4, SCREEN_WIDTH + 3);
      ys = pick(-4, rows + 3);
    end else if (r < 45) begin
      op = CMD_HSPAN;
      xs = pick(-40, SCREEN_WIDTH + 8);
      ys = pick(-2, rows + 1);
      ls = pick(-10, SCREEN_WIDTH + 40);
    end else if (r < 65) begin
      op = CMD_VSPAN;
      xs = pick(-2, SCREEN_WIDTH + 1);
      ys = pick(-20, rows + 4);
      ls = pick(-10, SCREEN_ROWS + 20);
    end else if (r < 67) begin
      op = CMD_CLEAR;
    end else if (r < 95) begin
      op = CMD_READ;
      xs = pick(-2, SCREEN_WIDTH + 1);
      ys = pick(-1, PAGE_COUNT);
    end else begin
      op = 3'($urandom_range(int'(CMD_READ) + 1, CMD_CODE_MAX));
    end
    send_command(op, xs, ys, ls, colour);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_setting(1'b1);

    send_command(CMD_READ, 0, 0, 0, COLOUR_NONE);
    send_command(CMD_PIXEL, 0, 0, 0, COLOUR_SET);
    send_command(CMD_PIXEL, 127, 31, 0, COLOUR_SET);
    send_command(CMD_PIXEL, 128, 0, 0, COLOUR_SET);
    send_command(CMD_PIXEL, -1, 32, 0, COLOUR_SET);
    send_command(CMD_PIXEL, -32768, -32768, -32768, COLOUR_TOGGLE);
    send_command(CMD_HSPAN, -5, 3, 10, COLOUR_SET);
    send_command(CMD_HSPAN, 120, 3, 20, COLOUR_TOGGLE);
    send_command(CMD_HSPAN, 10, 4, 0, COLOUR_SET);
    send_command(CMD_HSPAN, 10, 4, -7, COLOUR_SET);
    send_command(CMD_HSPAN, -32768, 5, 32767, COLOUR_SET);
    send_command(CMD_HSPAN, 0, 32, 50, COLOUR_SET);
    send_command(CMD_VSPAN, 5, -3, 40, COLOUR_SET);
    send_command(CMD_VSPAN, 6, 0, 32767, COLOUR_SET);
    send_command(CMD_VSPAN, 6, 8, 9, COLOUR_CLEAR);
    send_command(CMD_VSPAN, 128, 0, 10, COLOUR_SET);
    send_command(CMD_VSPAN, 7, 31, 5, COLOUR_TOGGLE);
    send_command(CMD_HSPAN, 0, 6, 128, COLOUR_NONE);
    send_command(CMD_READ, 5, 0, 0, COLOUR_NONE);
    send_command(CMD_READ, 127, 7, 0, COLOUR_NONE);
    send_command(CMD_READ, 0, 8, 0, COLOUR_NONE);
    send_command(CMD_READ, 32767, -32768, 0, COLOUR_NONE);
    send_command(3'(CMD_CODE_MAX), 1, 1, 1, COLOUR_SET);
    send_command(CMD_CLEAR, 0, 0, 0, COLOUR_NONE);
    send_command(CMD_READ, 5, 0, 0, COLOUR_NONE);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_setting(p % 2 == 1);
      repeat (PHASE_ITEMS) random_command();
    end
    wait_drained();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
